>>> hdl/arbc_pkg.sv
// arbc_pkg: shared types, codes and constants of the address range blocklist classifier
// no dependencies; imported by arbc_ctrl, arbc_datapath and the top level
package arbc_pkg;

    localparam int          TABLE_ENTRIES_DEFAULT = 4096;
    localparam logic [15:0] LOG_INTERVAL_RESET    = 16'd60;

    typedef enum logic [1:0] {
        OP_LOAD     = 2'd0,
        OP_CLASSIFY = 2'd1,
        OP_READ     = 2'd2,
        OP_UNUSED   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        HOOK_INBOUND  = 2'd0,
        HOOK_OUTBOUND = 2'd1,
        HOOK_FORWARD  = 2'd2,
        HOOK_OTHER    = 2'd3
    } hook_t;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT = 2'd0,
        VERDICT_DROP   = 2'd1,
        VERDICT_REPEAT = 2'd2,
        VERDICT_NONE   = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        CFG_ENTRY_COUNT  = 2'd0,
        CFG_ACCEPT_MARK  = 2'd1,
        CFG_REJECT_MARK  = 2'd2,
        CFG_LOG_INTERVAL = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SEL_IDX = 2'd0,
        SEL_SRC = 2'd1,
        SEL_DST = 2'd2
    } stat_sel_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_LOAD,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_SRCH_INIT,
        ST_SRCH_ISSUE,
        ST_SRCH_CMP,
        ST_UPD_SEL,
        ST_UPD_ISSUE,
        ST_UPD_WRITE,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic      clr_step;
        logic      capture;
        logic      load_wr;
        logic      srch_init;
        logic      srch_cmp;
        logic      upd_wr;
        logic      ehits_cap;
        logic      out_load;
        logic      phase;
        stat_sel_t stat_sel;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t   op;
        hook_t hook;
        logic  srch_active;
        logic  src_found;
        logic  dst_found;
        logic  clr_done;
        logic  out_free;
    } status_t;

endpackage

>>> hdl/arbc_ctrl.sv
// arbc_ctrl: sequencing state machine for load, read and classify transactions
// depends on arbc_pkg
module arbc_ctrl
    import arbc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t sts,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;

    // state and lookup phase registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clr_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                case (sts.op)
                    OP_LOAD: state_next = ST_LOAD;
                    OP_READ: state_next = ST_RD_ISSUE;
                    OP_CLASSIFY: begin
                        case (sts.hook)
                            HOOK_INBOUND, HOOK_FORWARD: begin
                                phase_next = 1'b0;
                                state_next = ST_SRCH_INIT;
                            end
                            HOOK_OUTBOUND: begin
                                phase_next = 1'b1;
                                state_next = ST_SRCH_INIT;
                            end
                            default: state_next = ST_FINISH;
                        endcase
                    end
                    default: state_next = ST_FINISH;
                endcase
            end
            ST_LOAD:      state_next = ST_FINISH;
            ST_RD_ISSUE:  state_next = ST_RD_WAIT;
            ST_RD_WAIT:   state_next = ST_FINISH;
            ST_SRCH_INIT: state_next = ST_SRCH_ISSUE;
            ST_SRCH_ISSUE: begin
                if (sts.srch_active) begin
                    state_next = ST_SRCH_CMP;
                end else if (!phase_reg && sts.hook == HOOK_FORWARD) begin
                    phase_next = 1'b1;
                    state_next = ST_SRCH_INIT;
                end else begin
                    state_next = ST_UPD_SEL;
                end
            end
            ST_SRCH_CMP: state_next = ST_SRCH_ISSUE;
            ST_UPD_SEL: begin
                if (sts.src_found) begin
                    phase_next = 1'b0;
                    state_next = ST_UPD_ISSUE;
                end else if (sts.dst_found) begin
                    phase_next = 1'b1;
                    state_next = ST_UPD_ISSUE;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_UPD_ISSUE: state_next = ST_UPD_WRITE;
            ST_UPD_WRITE: begin
                if (!phase_reg && sts.dst_found) begin
                    phase_next = 1'b1;
                    state_next = ST_UPD_ISSUE;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // commands
    always_comb begin
        cmd          = '0;
        cmd.phase    = phase_reg;
        cmd.stat_sel = SEL_IDX;
        s_ready      = 1'b0;
        case (state_reg)
            ST_CLEAR: cmd.clr_step = 1'b1;
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_LOAD:      cmd.load_wr = 1'b1;
            ST_RD_ISSUE:  cmd.stat_sel = SEL_IDX;
            ST_RD_WAIT:   cmd.ehits_cap = 1'b1;
            ST_SRCH_INIT: cmd.srch_init = 1'b1;
            ST_SRCH_CMP:  cmd.srch_cmp = 1'b1;
            ST_UPD_ISSUE: cmd.stat_sel = phase_reg ? SEL_DST : SEL_SRC;
            ST_UPD_WRITE: cmd.upd_wr = 1'b1;
            ST_FINISH:    cmd.out_load = sts.out_free;
            default:      cmd.stat_sel = SEL_IDX;
        endcase
    end

endmodule

>>> hdl/arbc_datapath.sv
// arbc_datapath: range and hit memories, binary search registers, counters and result register
// depends on arbc_pkg; driven by arbc_ctrl
module arbc_datapath
    import arbc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output status_t     sts,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic [1:0]  s_op,
    input  logic [11:0] s_entry_index,
    input  logic [31:0] s_range_low,
    input  logic [31:0] s_range_high,
    input  logic [1:0]  s_hook,
    input  logic [31:0] s_src_addr,
    input  logic [31:0] s_dst_addr,
    input  logic [31:0] s_now,
    input  logic [31:0] s_packet_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_packet_tag,
    output logic [1:0]  m_verdict,
    output logic [31:0] m_mark,
    output logic        m_log_event,
    output logic        m_src_hit,
    output logic        m_dst_hit,
    output logic [31:0] m_src_hits,
    output logic [31:0] m_dst_hits,
    output logic [31:0] m_entry_hits
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    // configuration registers
    logic [12:0] entry_count_reg;
    logic [31:0] accept_mark_reg;
    logic [31:0] reject_mark_reg;
    logic [15:0] log_interval_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg  <= '0;
            accept_mark_reg  <= '0;
            reject_mark_reg  <= '0;
            log_interval_reg <= LOG_INTERVAL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                CFG_ENTRY_COUNT:  entry_count_reg  <= cfg_wdata[12:0];
                CFG_ACCEPT_MARK:  accept_mark_reg  <= cfg_wdata;
                CFG_REJECT_MARK:  reject_mark_reg  <= cfg_wdata;
                CFG_LOG_INTERVAL: log_interval_reg <= cfg_wdata[15:0];
                default:          entry_count_reg  <= entry_count_reg;
            endcase
        end
    end

    // captured transaction
    op_t         op_reg;
    hook_t       hook_reg;
    logic [11:0] idx_reg;
    logic [31:0] rlo_reg, rhi_reg, src_reg, dst_reg, now_reg, pid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= op_t'(s_op);
            hook_reg <= hook_t'(s_hook);
            idx_reg  <= s_entry_index;
            rlo_reg  <= s_range_low;
            rhi_reg  <= s_range_high;
            src_reg  <= s_src_addr;
            dst_reg  <= s_dst_addr;
            now_reg  <= s_now;
            pid_reg  <= s_packet_id;
        end
    end

    logic [31:0]   idx_ext;
    logic          idx_ok;
    logic [AW-1:0] idx_addr;

    assign idx_ext  = {20'd0, idx_reg};
    assign idx_ok   = idx_ext < 32'(TABLE_ENTRIES);
    assign idx_addr = idx_ext[AW-1:0];

    // clearing pass over the hit memory after reset
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // binary search bounds
    logic [CW-1:0] lo_reg, hi_reg;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic [AW-1:0] mid_addr;
    logic [31:0]   count_ext, count_lim, key;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[CW:1];
    assign mid_addr  = mid[AW-1:0];
    assign count_ext = {19'd0, entry_count_reg};
    assign count_lim = (count_ext > 32'(TABLE_ENTRIES)) ? 32'(TABLE_ENTRIES) : count_ext;
    assign key       = cmd.phase ? dst_reg : src_reg;

    // range memory: {end, start}
    logic [63:0] range_mem [TABLE_ENTRIES];
    logic [63:0] range_rdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_wr && idx_ok) begin
            range_mem[idx_addr] <= {rhi_reg, rlo_reg};
        end
    end

    always_ff @(posedge aclk) begin
        range_rdata_reg <= range_mem[mid_addr];
    end

    // search results
    logic          sf_reg, df_reg;
    logic [AW-1:0] ss_reg, ds_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sf_reg <= 1'b0;
            df_reg <= 1'b0;
        end else if (cmd.srch_init) begin
            lo_reg <= '0;
            hi_reg <= count_lim[CW-1:0];
        end else if (cmd.srch_cmp) begin
            if (key < range_rdata_reg[31:0]) begin
                hi_reg <= mid;
            end else if (key > range_rdata_reg[63:32]) begin
                lo_reg <= mid + CW'(1);
            end else if (cmd.phase) begin
                df_reg <= 1'b1;
                ds_reg <= mid_addr;
            end else begin
                sf_reg <= 1'b1;
                ss_reg <= mid_addr;
            end
        end
    end

    // hit memory: {last hit, count}
    logic [63:0]   stat_mem [TABLE_ENTRIES];
    logic [63:0]   stat_rdata_reg;
    logic [AW-1:0] stat_raddr;
    logic          stat_we;
    logic [AW-1:0] stat_waddr;
    logic [63:0]   stat_wdata;
    logic [31:0]   cur_cnt, cur_last, new_cnt;

    assign cur_cnt  = stat_rdata_reg[31:0];
    assign cur_last = stat_rdata_reg[63:32];
    assign new_cnt  = (cur_cnt == 32'hFFFF_FFFF) ? cur_cnt : cur_cnt + 32'd1;

    always_comb begin
        case (cmd.stat_sel)
            SEL_SRC: stat_raddr = ss_reg;
            SEL_DST: stat_raddr = ds_reg;
            default: stat_raddr = idx_addr;
        endcase
    end

    always_comb begin
        stat_we    = 1'b0;
        stat_waddr = idx_addr;
        stat_wdata = '0;
        if (cmd.clr_step) begin
            stat_we    = 1'b1;
            stat_waddr = clr_cnt_reg;
        end else if (cmd.load_wr) begin
            stat_we    = idx_ok;
        end else if (cmd.upd_wr) begin
            stat_we    = 1'b1;
            stat_waddr = cmd.phase ? ds_reg : ss_reg;
            stat_wdata = {now_reg, new_cnt};
        end
    end

    always_ff @(posedge aclk) begin
        if (stat_we) begin
            stat_mem[stat_waddr] <= stat_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        stat_rdata_reg <= stat_mem[stat_raddr];
    end

    // counter update results
    logic [31:0] prev_reg, shits_reg, dhits_reg, ehits_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            prev_reg  <= '0;
            shits_reg <= '0;
            dhits_reg <= '0;
            ehits_reg <= '0;
        end else if (cmd.upd_wr) begin
            if (cur_last > prev_reg) prev_reg <= cur_last;
            if (cmd.phase) dhits_reg <= new_cnt;
            else           shits_reg <= new_cnt;
        end else if (cmd.ehits_cap && idx_ok) begin
            ehits_reg <= cur_cnt;
        end
    end

    // verdict composition
    logic        hit, stale, same_entry;
    logic [31:0] li_ext;
    verdict_t    verdict;
    logic [31:0] mark;

    assign hit        = sf_reg | df_reg;
    assign li_ext     = {16'd0, log_interval_reg};
    assign stale      = (now_reg >= li_ext) && (prev_reg < now_reg - li_ext);
    assign same_entry = sf_reg && df_reg && (ss_reg == ds_reg);

    always_comb begin
        verdict = VERDICT_NONE;
        mark    = '0;
        if (op_reg == OP_CLASSIFY && hook_reg != HOOK_OTHER) begin
            if (hit) begin
                if (hook_reg == HOOK_INBOUND || reject_mark_reg == '0) begin
                    verdict = VERDICT_DROP;
                end else begin
                    verdict = VERDICT_REPEAT;
                    mark    = reject_mark_reg;
                end
            end else if (accept_mark_reg != '0) begin
                verdict = VERDICT_REPEAT;
                mark    = accept_mark_reg;
            end else begin
                verdict = VERDICT_ACCEPT;
            end
        end
    end

    // result register
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_packet_tag <= pid_reg;
            m_verdict    <= verdict;
            m_mark       <= mark;
            m_log_event  <= hit && stale;
            m_src_hit    <= sf_reg;
            m_dst_hit    <= df_reg;
            m_src_hits   <= same_entry ? dhits_reg : shits_reg;
            m_dst_hits   <= dhits_reg;
            m_entry_hits <= ehits_reg;
        end
    end

    assign m_valid = m_valid_reg;

    // status
    assign sts.op          = op_reg;
    assign sts.hook        = hook_reg;
    assign sts.srch_active = (lo_reg < hi_reg) && !(cmd.phase ? df_reg : sf_reg);
    assign sts.src_found   = sf_reg;
    assign sts.dst_found   = df_reg;
    assign sts.clr_done    = clr_cnt_reg == AW'(TABLE_ENTRIES - 1);
    assign sts.out_free    = !m_valid_reg || m_ready;

endmodule

>>> hdl/address_range_blocklist_classifier_core.sv
// Address range blocklist classifier, top level: controller plus datapath.
// depends on arbc_pkg, arbc_ctrl and arbc_datapath
//
// One transaction at a time. After reset the block clears the hit memory before it
// first raises s_ready; configuration writes are taken meanwhile. A classify
// transaction runs a binary search lookup on the source address (inbound hook),
// the destination address (outbound) or both (forward), each of at most
// ceil(log2(entry_count + 1)) probes of the range memory, 13 for a full 4096-entry
// table, then a hit counter read-modify-write for each matched entry; an unknown
// hook skips the lookup. A finished result waits in the output register, and the
// next transaction is accepted while it waits.
module address_range_blocklist_classifier_core
    import arbc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [11:0] s_entry_index,
    input  logic [31:0] s_range_low,
    input  logic [31:0] s_range_high,
    input  logic [1:0]  s_hook,
    input  logic [31:0] s_src_addr,
    input  logic [31:0] s_dst_addr,
    input  logic [31:0] s_now,
    input  logic [31:0] s_packet_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_packet_tag,
    output logic [1:0]  m_verdict,
    output logic [31:0] m_mark,
    output logic        m_log_event,
    output logic        m_src_hit,
    output logic        m_dst_hit,
    output logic [31:0] m_src_hits,
    output logic [31:0] m_dst_hits,
    output logic [31:0] m_entry_hits
);

    cmd_t    cmd;
    status_t sts;

    // sequencing
    arbc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // storage and arithmetic
    arbc_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_op          (s_op),
        .s_entry_index (s_entry_index),
        .s_range_low   (s_range_low),
        .s_range_high  (s_range_high),
        .s_hook        (s_hook),
        .s_src_addr    (s_src_addr),
        .s_dst_addr    (s_dst_addr),
        .s_now         (s_now),
        .s_packet_id   (s_packet_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packet_tag  (m_packet_tag),
        .m_verdict     (m_verdict),
        .m_mark        (m_mark),
        .m_log_event   (m_log_event),
        .m_src_hit     (m_src_hit),
        .m_dst_hit     (m_dst_hit),
        .m_src_hits    (m_src_hits),
        .m_dst_hits    (m_dst_hits),
        .m_entry_hits  (m_entry_hits)
    );

endmodule
